/* hw/rtl/mcpi_pkg.sv */
// Shared types, constants, arithmetic helpers and microprogram of the current controller.
package mcpi_pkg;

  // Encoder resolution and fixed-point constants (signed Q16.16)
  localparam int COUNTS_PER_REV = 1200;
  localparam int DUTY_DIV       = 12;
  localparam int Q_ONE          = 65536;

  localparam logic signed [31:0] Q_TWO_PI    = 32'sd411769;
  localparam logic signed [31:0] Q_FF_GAIN   = 32'sd222822;
  localparam logic signed [31:0] Q_BACK_EMF  = 32'sd10486;
  localparam logic signed [31:0] Q_FIFTEEN   = 32'sd983040;
  localparam logic signed [31:0] Q_INT_CAP   = 32'sd131072;
  localparam logic signed [31:0] SPRING_GAIN = -32'sd200;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Datapath widths
  localparam int PROD_W = 64;
  localparam int TERM_W = 48;
  localparam int VACC_W = 50;
  localparam int DUTY_W = 18;

  // Constant divider: 4 quotient bits per cycle
  localparam int DIV_NUM_W     = 52;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_ITER      = DIV_NUM_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_ITER);
  localparam int DIV_DEN_MAX   = (COUNTS_PER_REV > DUTY_DIV) ? COUNTS_PER_REV : DUTY_DIV;
  localparam int DIV_DEN_W     = $clog2(DIV_DEN_MAX + 1);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic signed [23:0] velocity_count;
    logic        [15:0] current_adc;
  } in_word_t;

  typedef struct packed {
    logic        [16:0] duty_magnitude;
    logic               direction;
    logic signed [31:0] measured_current;
    logic signed [31:0] drive_voltage;
  } out_word_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            wdata;
  } cfg_word_t;

  // Microprogram
  localparam int PROG_LEN = 29;
  localparam int STEP_W   = $clog2(PROG_LEN);
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_IDLE = '0;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_AMPS, OP_MUL_POS, OP_DIV_1200, OP_THETA, OP_MUL_VEL, OP_OMEGA,
    OP_MUL_THETA, OP_SUB_OMEGA, OP_SET, OP_ERR, OP_INTEG, OP_MUL_FF, OP_RND, OP_ACC_FIRST,
    OP_MUL_KP, OP_ACC, OP_MUL_BEMF, OP_MUL_KI, OP_VOLT, OP_DIV_12, OP_DUTY, OP_OUT_LOAD
  } op_t;

  typedef enum logic [1:0] {
    C_NEVER, C_NO_START, C_DIV_BUSY, C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_word_t;

  typedef struct packed {
    op_t  op;
    logic fire;
    logic idle;
  } seq_out_t;

  typedef struct packed {
    logic start;
    logic div_busy;
    logic out_full;
  } seq_in_t;

  typedef struct packed {
    logic div_busy;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = SAT_MAX[31:0];
    else if (v < SAT_MIN) r = SAT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic ctrl_word_t cw(input op_t op, input cond_t cond, input step_t target,
                                    input logic last);
    ctrl_word_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Jump is taken when the condition holds; the step's operation fires otherwise
  function automatic ctrl_word_t prog_word(input step_t s);
    ctrl_word_t w;
    case (s)
      step_t'(0):  w = cw(OP_LATCH,     C_NO_START, step_t'(0),  1'b0);
      step_t'(1):  w = cw(OP_AMPS,      C_NEVER,    step_t'(0),  1'b0);
      step_t'(2):  w = cw(OP_MUL_POS,   C_NEVER,    step_t'(0),  1'b0);
      step_t'(3):  w = cw(OP_DIV_1200,  C_NEVER,    step_t'(0),  1'b0);
      step_t'(4):  w = cw(OP_THETA,     C_DIV_BUSY, step_t'(4),  1'b0);
      step_t'(5):  w = cw(OP_MUL_VEL,   C_NEVER,    step_t'(0),  1'b0);
      step_t'(6):  w = cw(OP_DIV_1200,  C_NEVER,    step_t'(0),  1'b0);
      step_t'(7):  w = cw(OP_OMEGA,     C_DIV_BUSY, step_t'(7),  1'b0);
      step_t'(8):  w = cw(OP_MUL_THETA, C_NEVER,    step_t'(0),  1'b0);
      step_t'(9):  w = cw(OP_SUB_OMEGA, C_NEVER,    step_t'(0),  1'b0);
      step_t'(10): w = cw(OP_SET,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(11): w = cw(OP_ERR,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(12): w = cw(OP_INTEG,     C_NEVER,    step_t'(0),  1'b0);
      step_t'(13): w = cw(OP_MUL_FF,    C_NEVER,    step_t'(0),  1'b0);
      step_t'(14): w = cw(OP_RND,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(15): w = cw(OP_ACC_FIRST, C_NEVER,    step_t'(0),  1'b0);
      step_t'(16): w = cw(OP_MUL_KP,    C_NEVER,    step_t'(0),  1'b0);
      step_t'(17): w = cw(OP_RND,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(18): w = cw(OP_ACC,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(19): w = cw(OP_MUL_BEMF,  C_NEVER,    step_t'(0),  1'b0);
      step_t'(20): w = cw(OP_RND,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(21): w = cw(OP_ACC,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(22): w = cw(OP_MUL_KI,    C_NEVER,    step_t'(0),  1'b0);
      step_t'(23): w = cw(OP_RND,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(24): w = cw(OP_ACC,       C_NEVER,    step_t'(0),  1'b0);
      step_t'(25): w = cw(OP_VOLT,      C_NEVER,    step_t'(0),  1'b0);
      step_t'(26): w = cw(OP_DIV_12,    C_NEVER,    step_t'(0),  1'b0);
      step_t'(27): w = cw(OP_DUTY,      C_DIV_BUSY, step_t'(27), 1'b0);
      step_t'(28): w = cw(OP_OUT_LOAD,  C_OUT_FULL, step_t'(28), 1'b1);
      default:     w = cw(OP_NOP,       C_NEVER,    step_t'(0),  1'b1);
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/mcpi_ifs.sv */
// Valid/ready channel interfaces for sample, result and configuration words.
interface mcpi_in_if;
  import mcpi_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcpi_out_if;
  import mcpi_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcpi_cfg_if;
  import mcpi_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/mcpi_divider.sv */
// Multi-cycle signed divider by a small constant, rounding half away from zero.
module mcpi_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mcpi_pkg::DIV_NUM_W-1:0] num,
  input  logic        [mcpi_pkg::DIV_DEN_W-1:0] den,
  output logic                                 busy,
  output logic signed [mcpi_pkg::DIV_NUM_W-1:0] quot
);
  import mcpi_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIX  = 3'b100
  } dv_state_t;

  dv_state_t                state;
  logic                     neg;
  logic [DIV_NUM_W-1:0]     dvd;
  logic [DIV_DEN_W-1:0]     rem;
  logic [DIV_DEN_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0]     cnt;
  logic [DIV_NUM_W-1:0]     abs_num;
  logic [DIV_NUM_W-1:0]     dvd_step;
  logic [DIV_DEN_W-1:0]     rem_step;
  logic [DIV_DEN_W:0]       trial;

  assign abs_num = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);

  // restoring steps, quotient bits shift into the dividend register
  always_comb begin
    rem_step = rem;
    dvd_step = dvd;
    trial    = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial    = {rem_step, dvd_step[DIV_NUM_W-1]};
      dvd_step = {dvd_step[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_step    = DIV_DEN_W'(trial - {1'b0, den_q});
        dvd_step[0] = 1'b1;
      end else begin
        rem_step = trial[DIV_DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        DV_IDLE: begin
          if (start) begin
            state <= DV_RUN;
            cnt   <= '0;
          end
        end
        DV_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_ITER - 1)) state <= DV_FIX;
        end
        DV_FIX:  state <= DV_IDLE;
        default: state <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          neg   <= num[DIV_NUM_W-1];
          dvd   <= abs_num + DIV_NUM_W'(den >> 1);
          rem   <= '0;
          den_q <= den;
        end
      end
      DV_RUN: begin
        dvd <= dvd_step;
        rem <= rem_step;
      end
      DV_FIX:  quot <= neg ? -$signed(dvd) : $signed(dvd);
      default: ;
    endcase
  end

  assign busy = (state != DV_IDLE);

endmodule

/* hw/rtl/mcpi_datapath.sv */
// Q16.16 datapath: working registers, shared multiplier, divider and result register.
module mcpi_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  mcpi_pkg::seq_out_t    ctrl,
  input  mcpi_pkg::in_word_t    in_word,
  input  logic                  cfg_we,
  input  mcpi_pkg::cfg_word_t   cfg_word,
  output mcpi_pkg::dp_status_t  status,
  output mcpi_pkg::out_word_t   out_word
);
  import mcpi_pkg::*;

  logic signed [31:0]        kp, ki, integ;
  logic signed [31:0]        pos, theta, omega, amps, set, err, volt;
  logic signed [23:0]        vel;
  logic        [15:0]        adc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  term;
  logic signed [VACC_W-1:0]  vacc;
  logic signed [DUTY_W-1:0]  duty;

  logic signed [31:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0]  rnd4, rnd16;
  logic signed [32:0]        e33, i33;
  logic        [20:0]        adc30;
  logic                      div_start, div_busy;
  logic signed [DIV_NUM_W-1:0] div_num, quot;
  logic        [DIV_DEN_W-1:0] div_den;
  logic                      fire;

  assign fire = ctrl.fire;

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.op)
      OP_MUL_POS:   begin mul_a = pos;        mul_b = Q_TWO_PI;   end
      OP_MUL_VEL:   begin mul_a = 32'(vel);   mul_b = Q_TWO_PI;   end
      OP_MUL_THETA: begin mul_a = theta;      mul_b = SPRING_GAIN; end
      OP_MUL_FF:    begin mul_a = Q_FF_GAIN;  mul_b = set;        end
      OP_MUL_KP:    begin mul_a = kp;         mul_b = err;        end
      OP_MUL_BEMF:  begin mul_a = Q_BACK_EMF; mul_b = omega;      end
      OP_MUL_KI:    begin mul_a = ki;         mul_b = integ;      end
      default:      begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  // round half away from zero on right shifts
  assign rnd4  = prod + (prod[PROD_W-1] ? PROD_W'(7) : PROD_W'(8));
  assign rnd16 = prod + (prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
  assign e33   = 33'(set) - 33'(amps);
  assign i33   = 33'(integ) + 33'(err);
  assign adc30 = 21'(adc) * 21'd30;

  assign div_start = fire && (ctrl.op == OP_DIV_1200 || ctrl.op == OP_DIV_12);
  assign div_num   = (ctrl.op == OP_DIV_12) ? DIV_NUM_W'(volt) : prod[DIV_NUM_W-1:0];
  assign div_den   = (ctrl.op == OP_DIV_12) ? DIV_DEN_W'(DUTY_DIV)
                                            : DIV_DEN_W'(COUNTS_PER_REV);

  mcpi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign status.div_busy = div_busy;

  // gains and integrator are state
  always_ff @(posedge clk) begin
    if (rst) begin
      kp    <= '0;
      ki    <= '0;
      integ <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_word.index)
          REG_PROP_GAIN:     kp <= cfg_word.wdata;
          REG_INTEGRAL_GAIN: ki <= cfg_word.wdata;
          default: ;
        endcase
      end
      if (fire && ctrl.op == OP_INTEG) begin
        if (i33 > 33'(Q_INT_CAP)) integ <= Q_INT_CAP;
        else integ <= sat32(64'(i33));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (ctrl.op)
        OP_LATCH: begin
          pos <= in_word.position_count;
          vel <= in_word.velocity_count;
          adc <= in_word.current_adc;
        end
        OP_AMPS:      amps  <= Q_FIFTEEN - 32'(adc30);
        OP_MUL_POS, OP_MUL_VEL, OP_MUL_THETA, OP_MUL_FF, OP_MUL_KP, OP_MUL_BEMF,
        OP_MUL_KI:    prod  <= 64'(mul_a) * 64'(mul_b);
        OP_THETA:     theta <= sat32(64'(quot));
        OP_OMEGA:     omega <= sat32(64'(quot));
        OP_SUB_OMEGA: prod  <= prod - 64'(omega);
        OP_SET:       set   <= sat32(rnd4 >>> 4);
        OP_ERR:       err   <= sat32(64'(e33));
        OP_RND:       term  <= rnd16[PROD_W-1:16];
        OP_ACC_FIRST: vacc  <= VACC_W'(term);
        OP_ACC:       vacc  <= vacc + VACC_W'(term);
        OP_VOLT:      volt  <= sat32(64'(vacc));
        OP_DUTY: begin
          if (quot > DIV_NUM_W'(Q_ONE)) duty <= DUTY_W'(Q_ONE);
          else if (quot < DIV_NUM_W'(-Q_ONE)) duty <= DUTY_W'(-Q_ONE);
          else duty <= quot[DUTY_W-1:0];
        end
        OP_OUT_LOAD: begin
          out_word.direction        <= duty[DUTY_W-1];
          out_word.duty_magnitude   <= duty[DUTY_W-1] ? 17'(-duty) : 17'(duty);
          out_word.measured_current <= amps;
          out_word.drive_voltage    <= volt;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/mcpi_sequencer.sv */
// Step counter and microprogram ROM with conditional jumps.
module mcpi_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  mcpi_pkg::seq_in_t  sin,
  output mcpi_pkg::seq_out_t sout
);
  import mcpi_pkg::*;

  step_t      step, step_next;
  ctrl_word_t word;
  logic       jump;

  assign word = prog_word(step);

  always_comb begin
    case (word.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_START: jump = !sin.start;
      C_DIV_BUSY: jump = sin.div_busy;
      C_OUT_FULL: jump = sin.out_full;
      default:    jump = 1'b0;
    endcase
    if (jump) step_next = word.target;
    else if (word.last) step_next = STEP_IDLE;
    else step_next = step_t'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) step <= STEP_IDLE;
    else step <= step_next;
  end

  assign sout.op   = word.op;
  assign sout.fire = !jump;
  assign sout.idle = (step == STEP_IDLE);

endmodule

/* hw/rtl/motor_current_pi_controller_core.sv */
// Top level of the motor current PI controller with spring-damper set current.
//
// One word on sample is one tick of the current loop: position, velocity and
// raw current are scaled to Q16.16 angle, angular velocity and amps, a
// spring-damper set current and the current error are formed, the error is
// integrated (capped at 2.0 above, saturating below) and the drive voltage
// 3.4*set + kp*err + 0.16*omega + ki*integral gives a clamped duty as
// magnitude plus direction. Each sample yields exactly one result word.
// A sample is taken only while the sequencer sits in its idle step; it
// returns there after the last step loads the result register. The program
// makes three passes through the constant divider (two by counts per
// revolution, one by 12) at four quotient bits per cycle. A result waiting
// on a stalled output does not block the next sample, which runs until it
// too needs the output register. prop_gain and integral_gain are written on
// cfg (index 0 and 1, other indexes ignored); the user must write them only
// while the block is idle, and the block itself does not enforce this.
module motor_current_pi_controller_core (
  input  logic        clk,
  input  logic        rst,
  mcpi_in_if.sink     sample,
  mcpi_out_if.source  result,
  mcpi_cfg_if.sink    cfg
);
  import mcpi_pkg::*;

  seq_in_t    sin;
  seq_out_t   sout;
  dp_status_t status;
  logic       out_full;
  logic       load;

  assign sample.ready = sout.idle;
  assign cfg.ready    = 1'b1;
  assign load         = sout.fire && (sout.op == OP_OUT_LOAD);

  assign sin.start    = sample.valid;
  assign sin.div_busy = status.div_busy;
  assign sin.out_full = out_full;

  mcpi_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .sin  (sin),
    .sout (sout)
  );

  mcpi_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sout),
    .in_word  (sample.data),
    .cfg_we   (cfg.valid),
    .cfg_word (cfg.data),
    .status   (status),
    .out_word (result.data)
  );

  // result register occupancy
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (load) out_full <= 1'b1;
    else if (result.valid && result.ready) out_full <= 1'b0;
  end

  assign result.valid = out_full;

  // result register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !out_full)
    else $error("result register loaded while full");

  // an accepted sample starts the program
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sout.idle)
    else $error("sequencer stayed idle after accepting a sample");

  // divider never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (sout.fire && (sout.op == OP_DIV_1200 || sout.op == OP_DIV_12)) |-> !status.div_busy)
    else $error("divider started while busy");

  // a waiting result clears only when taken
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    ($fell(out_full) && !$past(rst)) |-> $past(result.ready))
    else $error("result word dropped");

endmodule

/* tb/motor_current_pi_controller_core_tb.sv */
// Testbench for the motor current PI controller core: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module motor_current_pi_controller_core_tb;
  import mcpi_pkg::*;

  // Loop constants, Q16.16 where fractional
  localparam longint TICKS_PER_REV  = 1200;
  localparam longint TWO_PI_Q       = 411769;
  localparam longint FEEDFWD_Q      = 222822;
  localparam longint BACK_EMF_Q     = 10486;
  localparam longint FIFTEEN_AMPS_Q = 983040;
  localparam longint INTEG_CEIL_Q   = 131072;
  localparam longint FULL_DUTY_Q    = 65536;
  localparam longint VOLTS_PER_DUTY = 12;
  localparam longint WORD_MAX       = 64'sd2147483647;
  localparam longint WORD_MIN       = -64'sd2147483648;

  localparam logic [31:0] GAIN_MAX = 32'h7fff_ffff;
  localparam logic [31:0] GAIN_MIN = 32'h8000_0000;
  localparam logic [31:0] GAIN_ONE = 32'h0001_0000;
  localparam logic [31:0] GAIN_HALF = 32'h0000_8000;

  // an index beyond the register list; the block must drop the write
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 100;

  // Predictor of the current loop plus store of expected result words
  class current_loop_scoreboard;
    longint prop_gain;
    longint integral_gain;
    longint error_integral;
    out_word_t expected_words[$];
    int mismatches;

    function new();
      prop_gain = 0;
      integral_gain = 0;
      error_integral = 0;
      mismatches = 0;
    endfunction

    function longint div_nearest(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    function longint clip_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    function longint q_product(longint a, longint b);
      return div_nearest(a * b, 65536);
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
      if (idx == REG_PROP_GAIN) prop_gain = longint'($signed(value));
      else if (idx == REG_INTEGRAL_GAIN) integral_gain = longint'($signed(value));
    endfunction

    // One loop tick; updates the integrator
    function out_word_t predict_tick(in_word_t w);
      longint pos, vel, adc, theta, omega, amps, set_amps, err, acc, volts, duty;
      out_word_t r;
      pos = longint'($signed(w.position_count));
      vel = longint'($signed(w.velocity_count));
      adc = longint'($unsigned(w.current_adc));

      theta = clip_word(div_nearest(pos * TWO_PI_Q, TICKS_PER_REV));
      omega = clip_word(div_nearest(vel * TWO_PI_Q, TICKS_PER_REV));
      amps  = clip_word(FIFTEEN_AMPS_Q - adc * 30);

      // spring-damper command, kept exact as (-200*theta - omega)/16
      set_amps = clip_word(div_nearest(-200 * theta - omega, 16));
      err = clip_word(set_amps - amps);

      acc = error_integral + err;
      if (acc > INTEG_CEIL_Q) acc = INTEG_CEIL_Q;
      error_integral = clip_word(acc);

      volts = clip_word(q_product(FEEDFWD_Q, set_amps) + q_product(prop_gain, err)
                        + q_product(BACK_EMF_Q, omega)
                        + q_product(integral_gain, error_integral));

      duty = div_nearest(volts, VOLTS_PER_DUTY);
      if (duty > FULL_DUTY_Q) duty = FULL_DUTY_Q;
      if (duty < -FULL_DUTY_Q) duty = -FULL_DUTY_Q;

      r.direction        = (duty < 0);
      r.duty_magnitude   = 17'((duty < 0) ? -duty : duty);
      r.measured_current = 32'(amps);
      r.drive_voltage    = 32'(volts);
      return r;
    endfunction

    function void note_sample(in_word_t w);
      expected_words.push_back(predict_tick(w));
    endfunction

    function void compare_field(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing outstanding");
        return;
      end
      want = expected_words.pop_front();
      compare_field("duty_magnitude", $unsigned(want.duty_magnitude),
                    $unsigned(got.duty_magnitude));
      compare_field("direction", $unsigned(want.direction), $unsigned(got.direction));
      compare_field("measured_current", $signed(want.measured_current),
                    $signed(got.measured_current));
      compare_field("drive_voltage", $signed(want.drive_voltage),
                    $signed(got.drive_voltage));
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_words.size() == 0);
    endfunction
  endclass

  logic clk;
  logic rst;

  mcpi_in_if  sample_ch ();
  mcpi_out_if result_ch ();
  mcpi_cfg_if cfg_ch ();

  motor_current_pi_controller_core DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  current_loop_scoreboard sb = new();

  // idling odds in percent, set per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests  = 0;
  int holds_seen     = 0;
  int hold_left      = 0;
  int cycles         = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result words are checked at the edge that moves them
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one sample word; entered and left at a falling edge.
  // Here valid is dropped only ahead of an idle gap, so it never drops and rises in one step.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= w;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(w);
    @(negedge clk);
  endtask

  task automatic tick(input logic [31:0] pos, input logic [23:0] vel, input logic [15:0] adc);
    in_word_t w;
    w.position_count = pos;
    w.velocity_count = vel;
    w.current_adc    = adc;
    send_word(w);
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_register(idx, value);
    @(negedge clk);
  endtask

  // Only called with the block idle, straight after a drain
  task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, $urandom());
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_gain();
    logic [31:0] g;
    case ($urandom_range(7))
      0: g = '0;
      1: g = GAIN_MAX;
      2: g = GAIN_MIN;
      3: g = $urandom();
      default: g = $urandom_range(524288) - 262144; // within +-4.0
    endcase
    return g;
  endfunction

  // Mostly plausible operating points; the rest spread over the full fields
  function automatic in_word_t random_tick();
    in_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    w.current_adc = 16'($urandom_range(65535));
    if (pick < 70) begin
      w.position_count = $urandom_range(6000) - 3000;
      w.velocity_count = 24'($urandom_range(200000) - 100000);
    end else if (pick < 85) begin
      w.position_count = $urandom_range(4000000) - 2000000;
      w.velocity_count = 24'($urandom());
    end else begin
      w.position_count = $urandom();
      w.velocity_count = 24'($urandom());
    end
    return w;
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.data  = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset gains: field extremes and the zero-current midpoint
    tick(32'd0, 24'd0, 16'd0);
    tick(32'h7fff_ffff, 24'h7f_ffff, 16'hffff);
    tick(32'h8000_0000, 24'h80_0000, 16'h0000);
    tick(32'd0, 24'd0, 16'd32768);
    tick(32'd1, -24'sd1, 16'd32767);
    drain();

    // Integrator: drive it to the floor, then back up against the 2.0 ceiling
    load_gains(GAIN_ONE, GAIN_HALF);
    tick(32'h7fff_ffff, 24'd0, 16'd0);
    tick(32'h7fff_ffff, 24'd0, 16'd0);
    tick(32'h8000_0000, 24'd0, 16'hffff);
    tick(32'h8000_0000, 24'd0, 16'hffff);
    // angle and velocity just around the scaling limit
    tick(32'd6258600, -24'sd6258600, 16'd1000);
    tick(-32'sd6258601, 24'sd6258601, 16'd64000);
    drain();

    // Tiny negative voltages: duty rounds to zero, then a half rounds away
    load_gains(32'hffff_e666, '0);
    tick(32'd0, 24'd0, 16'd32769);
    tick(32'd0, 24'd0, 16'd32769);
    tick(32'd0, 24'd0, 16'd32770);
    drain();

    // Extreme gains: voltage saturation and duty clamp both ways
    load_gains(GAIN_MAX, GAIN_MIN);
    tick(-32'sd5000, 24'd0, 16'd0);
    tick(32'sd5000, 24'sd100, 16'hffff);
    tick(32'h8000_0000, 24'h7f_ffff, 16'd12345);
    drain();
    load_gains(GAIN_MIN, GAIN_MAX);
    tick(-32'sd5000, -24'sd100, 16'd0);
    tick(32'sd5000, 24'd0, 16'hffff);
    drain();

    // Random part: idling modes cycle none / sender / receiver / both
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) load_gains(GAIN_ONE, 32'h0000_0400);
      else load_gains(pick_gain(), pick_gain());
      // receiver holds off while words keep coming, so the block backs up
      if (phase % 4 == 0) hold_requests++;
      for (n = 0; n < TICKS_PER_PHASE; n++) send_word(random_tick());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.clean()) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
